[rtl/pbsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_pkg
// Shared types and constants of the point/box signed distance pipeline.
// ----------------------------------------------------------------------------
package pbsd_pkg;

  localparam int unsigned DIST_W    = 32;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned REGION_W  = 4;
  localparam int unsigned NORM_FRAC = 14;   // Q2.14
  localparam int unsigned SQ_W      = 64;   // radicand width
  localparam int unsigned ROOT_W    = SQ_W / 2;
  localparam int unsigned QUO_W     = NORM_FRAC + 1;
  localparam int unsigned NUM_W     = 31 + NORM_FRAC + 2;

  localparam logic [NORM_W-1:0] NORM_ONE     = 16'h4000;
  localparam logic [DIST_W-1:0] DIST_SAT     = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_NEG_LIM = 32'h8000_0000;

  typedef enum logic [REGION_W-1:0] {
    RGN_CORNER_LL = 4'd0,
    RGN_CORNER_HL = 4'd1,
    RGN_CORNER_LH = 4'd2,
    RGN_CORNER_HH = 4'd3,
    RGN_FACE_XMIN = 4'd4,
    RGN_FACE_XMAX = 4'd5,
    RGN_FACE_YMIN = 4'd6,
    RGN_FACE_YMAX = 4'd7,
    RGN_INSIDE    = 4'd8
  } region_e;

  typedef enum logic [1:0] {
    CFG_MIN_X = 2'd0,
    CFG_MIN_Y = 2'd1,
    CFG_MAX_X = 2'd2,
    CFG_MAX_Y = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic    corner;
    logic    sat;     // a corner gap is 2^31 or more
    logic    xneg;
    logic    yneg;
    region_e region;
  } ctl_t;

  typedef struct packed {
    logic [DIST_W-1:0] sdist;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
  } res_t;

endpackage
`default_nettype wire

[rtl/pbsd_classify.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_classify
// Two stages: coordinate differences, then region decision, face/inside
// results and the corner gap magnitudes.
// ----------------------------------------------------------------------------
module pbsd_classify #(
  parameter int unsigned CW = 32,
  parameter int unsigned GW = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     vld_i,
  input  wire  [CW-1:0]           px_i,
  input  wire  [CW-1:0]           py_i,
  input  wire  [CW-1:0]           min_x_i,
  input  wire  [CW-1:0]           min_y_i,
  input  wire  [CW-1:0]           max_x_i,
  input  wire  [CW-1:0]           max_y_i,
  output logic                    vld_o,
  output pbsd_pkg::ctl_t          ctl_o,
  output pbsd_pkg::res_t          res_o,
  output logic [GW-1:0]           a_o,
  output logic [GW-1:0]           b_o
);
  import pbsd_pkg::*;

  logic          vld_a_q, vld_b_q;
  logic [CW:0]   e_d [4];
  logic [CW:0]   e_q [4];
  logic [CW:0]   n   [4];
  logic [GW-1:0] pos [4];
  logic [GW-1:0] neg [4];
  logic          lt_x, gt_x, lt_y, gt_y;
  logic [GW-1:0] ax, ay, bg;
  logic [1:0]    best;
  ctl_t          ctl_d, ctl_q;
  res_t          res_d, res_q;
  logic [GW-1:0] a_q, b_q;

  function automatic logic [DIST_W-1:0] sat_pos(input logic [GW-1:0] g);
    sat_pos = ((g >> 31) != '0) ? DIST_SAT : g[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sat_neg(input logic [GW-1:0] g);
    sat_neg = ((g >> 31) != '0) ? DIST_NEG_LIM : (DIST_W'(0) - g[DIST_W-1:0]);
  endfunction

  always_comb begin
    e_d[0] = {px_i[CW-1], px_i} - {min_x_i[CW-1], min_x_i};
    e_d[1] = {max_x_i[CW-1], max_x_i} - {px_i[CW-1], px_i};
    e_d[2] = {py_i[CW-1], py_i} - {min_y_i[CW-1], min_y_i};
    e_d[3] = {max_y_i[CW-1], max_y_i} - {py_i[CW-1], py_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q   <= e_d;
      ctl_q <= ctl_d;
      res_q <= res_d;
      a_q   <= ax;
      b_q   <= ay;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n[i]   = (CW+1)'(0) - e_q[i];
      pos[i] = GW'(e_q[i][CW-1:0]);
      neg[i] = GW'(n[i][CW-1:0]);
    end
    lt_x = e_q[0][CW];
    gt_x = e_q[1][CW];
    lt_y = e_q[2][CW];
    gt_y = e_q[3][CW];

    ax = lt_x ? neg[0] : neg[1];
    ay = gt_y ? neg[3] : neg[2];

    // nearest inside face, later faces win only when strictly closer
    best = 2'd0;
    bg   = pos[0];
    for (int i = 1; i < 4; i++) begin
      if (pos[i] < bg) begin
        best = 2'(i);
        bg   = pos[i];
      end
    end

    ctl_d        = '0;
    ctl_d.xneg   = lt_x;
    ctl_d.yneg   = !gt_y;
    ctl_d.sat    = ((ax >> 31) != '0) || ((ay >> 31) != '0);
    ctl_d.region = RGN_INSIDE;
    res_d        = '0;

    if (lt_x || gt_x) begin
      if (gt_y || lt_y) begin
        ctl_d.corner = 1'b1;
        case ({gt_y, lt_x})
          2'b01:   ctl_d.region = RGN_CORNER_LL;
          2'b00:   ctl_d.region = RGN_CORNER_HL;
          2'b11:   ctl_d.region = RGN_CORNER_LH;
          default: ctl_d.region = RGN_CORNER_HH;
        endcase
      end else begin
        res_d.sdist  = sat_pos(ax);
        res_d.nx     = lt_x ? (NORM_W'(0) - NORM_ONE) : NORM_ONE;
        ctl_d.region = lt_x ? RGN_FACE_XMIN : RGN_FACE_XMAX;
      end
    end else if (lt_y) begin
      res_d.sdist  = sat_pos(neg[2]);
      res_d.ny     = NORM_W'(0) - NORM_ONE;
      ctl_d.region = RGN_FACE_YMIN;
    end else if (gt_y) begin
      res_d.sdist  = sat_pos(neg[3]);
      res_d.ny     = NORM_ONE;
      ctl_d.region = RGN_FACE_YMAX;
    end else begin
      res_d.sdist = sat_neg(bg);
      case (best)
        2'd0:    res_d.nx = NORM_W'(0) - NORM_ONE;
        2'd1:    res_d.nx = NORM_ONE;
        2'd2:    res_d.ny = NORM_W'(0) - NORM_ONE;
        default: res_d.ny = NORM_ONE;
      endcase
    end
  end

  assign vld_o = vld_b_q;
  assign ctl_o = ctl_q;
  assign res_o = res_q;
  assign a_o   = a_q;
  assign b_o   = b_q;

endmodule
`default_nettype wire

[rtl/pbsd_norm.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_norm
// Scales a gap pair together until the larger lies in [2^30, 2^31):
// six right-shift stages (32..1, truncating) then five left-shift stages.
// ----------------------------------------------------------------------------
module pbsd_norm #(
  parameter int unsigned GW  = 32,
  parameter int unsigned SBW = 8
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            en_i,
  input  wire            vld_i,
  input  wire  [GW-1:0]  a_i,
  input  wire  [GW-1:0]  b_i,
  input  wire  [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [30:0]    a_o,
  output logic [30:0]    b_o,
  output logic [SBW-1:0] sb_o
);

  localparam int unsigned NS = 11;

  logic [GW-1:0]  a_w  [NS+1];
  logic [GW-1:0]  b_w  [NS+1];
  logic [SBW-1:0] sb_w [NS+1];
  logic           v_w  [NS+1];

  assign a_w[0]  = a_i;
  assign b_w[0]  = b_i;
  assign sb_w[0] = sb_i;
  assign v_w[0]  = vld_i;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam bit          RIGHT = (j < 6);
    localparam int unsigned K     = RIGHT ? (32 >> j) : (16 >> (j - 6));
    logic [GW-1:0]  o;
    logic           sh;
    logic [GW-1:0]  a_q, b_q;
    logic [SBW-1:0] sb_q;
    logic           v_q;

    assign o  = a_w[j] | b_w[j];   // same bit length as the larger
    assign sh = RIGHT ? ((o >> (30 + K)) != '0)
                      : ((o != '0) && ((o >> (31 - K)) == '0));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q <= sb_w[j];
        if (!sh) begin
          a_q <= a_w[j];
          b_q <= b_w[j];
        end else if (RIGHT) begin
          a_q <= a_w[j] >> K;
          b_q <= b_w[j] >> K;
        end else begin
          a_q <= a_w[j] << K;
          b_q <= b_w[j] << K;
        end
      end
    end

    assign a_w[j+1]  = a_q;
    assign b_w[j+1]  = b_q;
    assign sb_w[j+1] = sb_q;
    assign v_w[j+1]  = v_q;
  end

  assign vld_o = v_w[NS];
  assign a_o   = a_w[NS][30:0];
  assign b_o   = b_w[NS][30:0];
  assign sb_o  = sb_w[NS];

endmodule
`default_nettype wire

[rtl/pbsd_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_isqrt
// Two-lane pipelined integer square root, one result bit per stage.
// Lane 0 also flags round-to-nearest (remainder above root).
// ----------------------------------------------------------------------------
module pbsd_isqrt #(
  parameter int unsigned SBW = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          vld_i,
  input  wire  [pbsd_pkg::SQ_W-1:0]    s0_i,
  input  wire  [pbsd_pkg::SQ_W-1:0]    s1_i,
  input  wire  [SBW-1:0]               sb_i,
  output logic                         vld_o,
  output logic [pbsd_pkg::ROOT_W-1:0]  r0_o,
  output logic                         up0_o,
  output logic [pbsd_pkg::ROOT_W-1:0]  r1_o,
  output logic [SBW-1:0]               sb_o
);
  import pbsd_pkg::*;

  localparam int unsigned NS = SQ_W / 2;
  localparam int unsigned XW = SQ_W + 1;

  logic [XW-1:0]  rm_w [2][NS+1];
  logic [XW-1:0]  rt_w [2][NS+1];
  logic [SBW-1:0] sb_w [NS+1];
  logic           v_w  [NS+1];

  assign rm_w[0][0] = XW'(s0_i);
  assign rm_w[1][0] = XW'(s1_i);
  assign rt_w[0][0] = '0;
  assign rt_w[1][0] = '0;
  assign sb_w[0]    = sb_i;
  assign v_w[0]     = vld_i;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic [XW-1:0] BIT = XW'(1) << (SQ_W - 2 - 2 * i);
    logic [SBW-1:0] sb_q;
    logic           v_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q <= sb_w[i];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [XW-1:0] t;
      logic [XW-1:0] rm_q, rt_q;

      assign t = rt_w[l][i] + BIT;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rm_w[l][i] >= t) begin
            rm_q <= rm_w[l][i] - t;
            rt_q <= (rt_w[l][i] >> 1) + BIT;
          end else begin
            rm_q <= rm_w[l][i];
            rt_q <= rt_w[l][i] >> 1;
          end
        end
      end

      assign rm_w[l][i+1] = rm_q;
      assign rt_w[l][i+1] = rt_q;
    end

    assign sb_w[i+1] = sb_q;
    assign v_w[i+1]  = v_q;
  end

  assign vld_o = v_w[NS];
  assign r0_o  = rt_w[0][NS][ROOT_W-1:0];
  assign up0_o = rm_w[0][NS] > rt_w[0][NS];
  assign r1_o  = rt_w[1][NS][ROOT_W-1:0];
  assign sb_o  = sb_w[NS];

endmodule
`default_nettype wire

[rtl/pbsd_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pbsd_div
// Pipelined restoring divider, two numerators over one divisor,
// one quotient bit per stage (quotient known to fit QUO_W bits).
// ----------------------------------------------------------------------------
module pbsd_div #(
  parameter int unsigned SBW = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire                          vld_i,
  input  wire  [pbsd_pkg::NUM_W-1:0]   nx_i,
  input  wire  [pbsd_pkg::NUM_W-1:0]   ny_i,
  input  wire  [pbsd_pkg::ROOT_W-1:0]  d_i,
  input  wire  [SBW-1:0]               sb_i,
  output logic                         vld_o,
  output logic [pbsd_pkg::QUO_W-1:0]   qx_o,
  output logic [pbsd_pkg::QUO_W-1:0]   qy_o,
  output logic [SBW-1:0]               sb_o
);
  import pbsd_pkg::*;

  localparam int unsigned NS = QUO_W;

  logic [NUM_W-1:0]  n_w  [2][NS+1];
  logic [QUO_W-1:0]  q_w  [2][NS+1];
  logic [ROOT_W-1:0] d_w  [NS+1];
  logic [SBW-1:0]    sb_w [NS+1];
  logic              v_w  [NS+1];

  assign n_w[0][0] = nx_i;
  assign n_w[1][0] = ny_i;
  assign q_w[0][0] = '0;
  assign q_w[1][0] = '0;
  assign d_w[0]    = d_i;
  assign sb_w[0]   = sb_i;
  assign v_w[0]    = vld_i;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int unsigned B = QUO_W - 1 - i;
    logic [NUM_W-1:0]  dsh;
    logic [ROOT_W-1:0] d_q;
    logic [SBW-1:0]    sb_q;
    logic              v_q;

    assign dsh = NUM_W'(d_w[i]) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q  <= d_w[i];
        sb_q <= sb_w[i];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NUM_W-1:0] n_q;
      logic [QUO_W-1:0] q_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (n_w[l][i] >= dsh) begin
            n_q <= n_w[l][i] - dsh;
            q_q <= q_w[l][i] | (QUO_W'(1) << B);
          end else begin
            n_q <= n_w[l][i];
            q_q <= q_w[l][i];
          end
        end
      end

      assign n_w[l][i+1] = n_q;
      assign q_w[l][i+1] = q_q;
    end

    assign d_w[i+1]  = d_q;
    assign sb_w[i+1] = sb_q;
    assign v_w[i+1]  = v_q;
  end

  assign vld_o = v_w[NS];
  assign qx_o  = q_w[0][NS];
  assign qy_o  = q_w[1][NS];
  assign sb_o  = sb_w[NS];

endmodule
`default_nettype wire

[rtl/point_box_signed_distance_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_box_signed_distance_top
// Signed distance and outward unit normal of a Q16.16 point against a box.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: px, py
//  m_axis    out  m_axis_tvalid/tready       tdata: signed_dist, normal_x, normal_y
//                                            tuser: region
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
//  One point per cycle unless stalled; stages: 2 classify, 11 normalize, 2 square,
//  32 square root, 1 round, 15 divide, 1 output register.
//  Reset clears all valid bits and loads the default unit box.
//  One enable drives every stage: the pipeline advances when the output
//  register is empty or being taken, so a stall freezes all stages in place.
//  Config writes are always taken.
// ----------------------------------------------------------------------------
module point_box_signed_distance_top #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      s_axis_tvalid,
  output logic                                     s_axis_tready,
  // px, py
  input  wire  [((2*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire                                      m_axis_tready,
  // signed_dist, normal_x, normal_y
  output logic [63:0]                              m_axis_tdata,
  // region
  output logic [3:0]                               m_axis_tuser,
  input  wire                                      cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire  [1:0]                               cfg_index_i,
  input  wire  [COORD_WIDTH-1:0]                   cfg_data_i
);
  import pbsd_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned GW  = (CW > 32) ? CW : 32;
  localparam int unsigned CTW = $bits(ctl_t);
  localparam int unsigned RSW = $bits(res_t);

  logic          en;
  logic [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= CW'(65536);
      max_y_q <= CW'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_X: min_x_q <= cfg_data_i;
        CFG_MIN_Y: min_y_q <= cfg_data_i;
        CFG_MAX_X: max_x_q <= cfg_data_i;
        CFG_MAX_Y: max_y_q <= cfg_data_i;
        default:   min_x_q <= cfg_data_i;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // classify
  logic          c_vld;
  ctl_t          c_ctl;
  res_t          c_res;
  logic [GW-1:0] c_a, c_b;

  pbsd_classify #(.CW(CW), .GW(GW)) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (s_axis_tvalid),
    .px_i    (s_axis_tdata[CW-1:0]),
    .py_i    (s_axis_tdata[2*CW-1:CW]),
    .min_x_i (min_x_q),
    .min_y_i (min_y_q),
    .max_x_i (max_x_q),
    .max_y_i (max_y_q),
    .vld_o   (c_vld),
    .ctl_o   (c_ctl),
    .res_o   (c_res),
    .a_o     (c_a),
    .b_o     (c_b)
  );

  // normalize; raw low gap bits ride along for the distance square
  localparam int unsigned NSBW = CTW + RSW + 62;
  logic            n_vld;
  logic [30:0]     n_a, n_b, n_ra, n_rb;
  logic [NSBW-1:0] n_sb;
  ctl_t            n_ctl;
  res_t            n_res;

  pbsd_norm #(.GW(GW), .SBW(NSBW)) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (c_vld),
    .a_i    (c_a),
    .b_i    (c_b),
    .sb_i   ({c_ctl, c_res, c_a[30:0], c_b[30:0]}),
    .vld_o  (n_vld),
    .a_o    (n_a),
    .b_o    (n_b),
    .sb_o   (n_sb)
  );

  assign {n_ctl, n_res, n_ra, n_rb} = n_sb;

  // squares, then sums
  logic        m_vld_q, s_vld_q;
  logic [61:0] m_aa_q, m_bb_q, m_na_q, m_nb_q;
  logic [30:0] m_a_q, m_b_q, s_a_q, s_b_q;
  ctl_t        m_ctl_q, s_ctl_q;
  res_t        m_res_q, s_res_q;
  logic [SQ_W-1:0] s_s0_q, s_s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= n_vld;
      s_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_aa_q  <= 62'(n_ra) * 62'(n_ra);
      m_bb_q  <= 62'(n_rb) * 62'(n_rb);
      m_na_q  <= 62'(n_a) * 62'(n_a);
      m_nb_q  <= 62'(n_b) * 62'(n_b);
      m_a_q   <= n_a;
      m_b_q   <= n_b;
      m_ctl_q <= n_ctl;
      m_res_q <= n_res;
      s_s0_q  <= SQ_W'(m_aa_q) + SQ_W'(m_bb_q);
      s_s1_q  <= SQ_W'(m_na_q) + SQ_W'(m_nb_q);
      s_a_q   <= m_a_q;
      s_b_q   <= m_b_q;
      s_ctl_q <= m_ctl_q;
      s_res_q <= m_res_q;
    end
  end

  // square roots: corner distance and normalized length
  localparam int unsigned QSBW = CTW + RSW + 62;
  logic              q_vld, q_up0;
  logic [ROOT_W-1:0] q_r0, q_r1;
  logic [QSBW-1:0]   q_sb;
  ctl_t              q_ctl;
  res_t              q_res;
  logic [30:0]       q_a, q_b;

  pbsd_isqrt #(.SBW(QSBW)) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_vld_q),
    .s0_i   (s_s0_q),
    .s1_i   (s_s1_q),
    .sb_i   ({s_ctl_q, s_res_q, s_a_q, s_b_q}),
    .vld_o  (q_vld),
    .r0_o   (q_r0),
    .up0_o  (q_up0),
    .r1_o   (q_r1),
    .sb_o   (q_sb)
  );

  assign {q_ctl, q_res, q_a, q_b} = q_sb;

  // rounding and divider operands
  logic              r_vld_q;
  logic [ROOT_W:0]   r_sum;
  logic [NUM_W-1:0]  r_nx_q, r_ny_q;
  logic [ROOT_W-1:0] r_d_q;
  logic [DIST_W-1:0] r_dist_q;
  logic              r_zero_q;
  ctl_t              r_ctl_q;
  res_t              r_res_q;

  assign r_sum = {1'b0, q_r0} + (ROOT_W+1)'(q_up0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_nx_q   <= (NUM_W'(q_a) << NORM_FRAC) + NUM_W'(q_r1 >> 1);
      r_ny_q   <= (NUM_W'(q_b) << NORM_FRAC) + NUM_W'(q_r1 >> 1);
      r_d_q    <= q_r1;
      r_zero_q <= (q_r1 == '0);
      r_ctl_q  <= q_ctl;
      r_res_q  <= q_res;
      if (q_ctl.sat || (r_sum > (ROOT_W+1)'(DIST_SAT))) begin
        r_dist_q <= DIST_SAT;
      end else begin
        r_dist_q <= r_sum[DIST_W-1:0];
      end
    end
  end

  // normal components
  localparam int unsigned DSBW = CTW + RSW + DIST_W + 1;
  logic             d_vld;
  logic [QUO_W-1:0] d_qx, d_qy;
  logic [DSBW-1:0]  d_sb;
  ctl_t             d_ctl;
  res_t             d_res;
  logic [DIST_W-1:0] d_dist;
  logic             d_zero;

  pbsd_div #(.SBW(DSBW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (r_vld_q),
    .nx_i   (r_nx_q),
    .ny_i   (r_ny_q),
    .d_i    (r_d_q),
    .sb_i   ({r_ctl_q, r_res_q, r_dist_q, r_zero_q}),
    .vld_o  (d_vld),
    .qx_o   (d_qx),
    .qy_o   (d_qy),
    .sb_o   (d_sb)
  );

  assign {d_ctl, d_res, d_dist, d_zero} = d_sb;

  // output register
  logic              o_vld_q;
  res_t              o_res_q, o_res_d;
  region_e           o_rgn_q;
  logic [NORM_W-1:0] ux, uy;

  always_comb begin
    ux = d_zero ? '0 : NORM_W'(d_qx);
    uy = d_zero ? '0 : NORM_W'(d_qy);
    if (d_ctl.corner) begin
      o_res_d.sdist = d_dist;
      o_res_d.nx    = d_ctl.xneg ? (NORM_W'(0) - ux) : ux;
      o_res_d.ny    = d_ctl.yneg ? (NORM_W'(0) - uy) : uy;
    end else begin
      o_res_d = d_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_res_q <= o_res_d;
      o_rgn_q <= d_ctl.region;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {o_res_q.ny, o_res_q.nx, o_res_q.sdist};
  assign m_axis_tuser  = o_rgn_q;

endmodule
`default_nettype wire

[verif/point_box_signed_distance_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_box_signed_distance_checker
// Watches the point, result and register channels, keeps its own copy of the
// box, predicts distance, normal and region for each point and compares.
// ----------------------------------------------------------------------------
module point_box_signed_distance_checker
  import pbsd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [63:0] s_axis_tdata,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [63:0] m_axis_tdata,
  input  wire  [3:0]  m_axis_tuser,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  output int          err_cnt_o,
  output int          pending_o,
  output int          result_cnt_o
);

  typedef struct packed {
    logic [DIST_W-1:0] sdist;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    region_e           region;
  } answer_t;

  answer_t answer_q[$];
  logic signed [31:0] bx_lo, by_lo, bx_hi, by_hi;

  assign pending_o = answer_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [NORM_W-1:0] unit_dir(bit neg);
    return neg ? -NORM_ONE : NORM_ONE;
  endfunction

  function automatic logic [31:0] clamp_gap(logic [63:0] g);
    return (g > 64'(DIST_SAT)) ? DIST_SAT : g[31:0];
  endfunction

  function automatic answer_t classify_point(logic signed [31:0] px,
                                             logic signed [31:0] py);
    answer_t ans;
    logic [63:0] ax, ay, a, b, m, s, r, qx, qy;
    logic [63:0] gap[4];
    bit left, top;
    int best;
    ans = '0;
    if (px < bx_lo || px > bx_hi) begin
      left = px < bx_lo;
      ax = left ? 64'($signed(64'(bx_lo)) - $signed(64'(px)))
                : 64'($signed(64'(px)) - $signed(64'(bx_hi)));
      if (py > by_hi || py < by_lo) begin
        top = py > by_hi;
        ay = top ? 64'($signed(64'(py)) - $signed(64'(by_hi)))
                 : 64'($signed(64'(by_lo)) - $signed(64'(py)));
        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
          ans.sdist = DIST_SAT;
        end else begin
          s = ax * ax + ay * ay;
          r = int_sqrt(s);
          if (s - r * r > r) r = r + 1;
          ans.sdist = clamp_gap(r);
        end
        a = ax;
        b = ay;
        m = (a > b) ? a : b;
        while (m >= 64'h8000_0000) begin
          a = a >> 1; b = b >> 1; m = m >> 1;
        end
        while (m != 0 && m < 64'h4000_0000) begin
          a = a << 1; b = b << 1; m = m << 1;
        end
        r = int_sqrt(a * a + b * b);
        if (r != 0) begin
          qx = (a * 64'(NORM_ONE) + r / 2) / r;
          qy = (b * 64'(NORM_ONE) + r / 2) / r;
          ans.nx = left ? -qx[15:0] : qx[15:0];
          ans.ny = top ? qy[15:0] : -qy[15:0];
        end
        ans.region = region_e'((left ? 0 : 1) + (top ? 2 : 0));
      end else begin
        ans.sdist = clamp_gap(ax);
        ans.nx = unit_dir(left);
        ans.region = left ? RGN_FACE_XMIN : RGN_FACE_XMAX;
      end
    end else if (py < by_lo) begin
      ans.sdist = clamp_gap(64'($signed(64'(by_lo)) - $signed(64'(py))));
      ans.ny = unit_dir(1'b1);
      ans.region = RGN_FACE_YMIN;
    end else if (py > by_hi) begin
      ans.sdist = clamp_gap(64'($signed(64'(py)) - $signed(64'(by_hi))));
      ans.ny = unit_dir(1'b0);
      ans.region = RGN_FACE_YMAX;
    end else begin
      gap[0] = 64'($signed(64'(px)) - $signed(64'(bx_lo)));
      gap[1] = 64'($signed(64'(bx_hi)) - $signed(64'(px)));
      gap[2] = 64'($signed(64'(py)) - $signed(64'(by_lo)));
      gap[3] = 64'($signed(64'(by_hi)) - $signed(64'(py)));
      best = 0;
      for (int i = 1; i < 4; i++) if (gap[i] < gap[best]) best = i;
      if (gap[best] > 64'h8000_0000) gap[best] = 64'h8000_0000;
      ans.sdist = -gap[best][31:0];
      if (best < 2) ans.nx = unit_dir(best == 0);
      else ans.ny = unit_dir(best == 2);
      ans.region = RGN_INSIDE;
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want, got;
    if (!rst_ni) begin
      bx_lo <= 0;
      by_lo <= 0;
      bx_hi <= 32'sd65536;
      by_hi <= 32'sd65536;
      err_cnt_o <= 0;
      result_cnt_o <= 0;
      answer_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt_o <= result_cnt_o + 1;
        got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[63:48],
               region_e'(m_axis_tuser)};
        if (answer_q.size() == 0) begin
          $display("%0t: result with none expected: %h", $realtime, got);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = answer_q.pop_front();
          if (got.sdist !== want.sdist || got.nx !== want.nx ||
              got.ny !== want.ny || got.region !== want.region) begin
            $display("%0t: mismatch dist/nx/ny/region expected %h/%h/%h/%0d actual %h/%h/%h/%0d",
                     $realtime, want.sdist, want.nx, want.ny, want.region,
                     got.sdist, got.nx, got.ny, got.region);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        answer_q.push_back(classify_point(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_X: bx_lo <= cfg_data_i;
          CFG_MIN_Y: by_lo <= cfg_data_i;
          CFG_MAX_X: bx_hi <= cfg_data_i;
          CFG_MAX_Y: by_hi <= cfg_data_i;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[verif/point_box_signed_distance_top_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_box_signed_distance_top_tb
// Writes a series of boxes, sends directed or random points against each,
// with random stalls on both streams; the checker compares every result.
// ----------------------------------------------------------------------------
module point_box_signed_distance_top_tb;
  import pbsd_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 5000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          err_cnt, pending, result_cnt;
  int          idle_cnt = 0;
  bit          no_stall = 0;
  int          box_cnt = 0;

  point_box_signed_distance_top dut (.*);

  point_box_signed_distance_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .err_cnt_o(err_cnt), .pending_o(pending), .result_cnt_o(result_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls at random except during the quiet stretch
  always @(negedge clk_i) m_axis_tready <= no_stall || ($urandom_range(99) >= 13);

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("point_box_signed_distance_top_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_box(logic [31:0] lx, logic [31:0] ly,
                          logic [31:0] hx, logic [31:0] hy);
    wait_drained();
    write_reg(CFG_MIN_X, lx);
    write_reg(CFG_MIN_Y, ly);
    write_reg(CFG_MAX_X, hx);
    write_reg(CFG_MAX_Y, hy);
    box_cnt++;
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py);
    @(negedge clk_i);
    while (!no_stall && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {py, px};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  // mostly points near the box, some across the whole range
  function automatic logic [31:0] near(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(5))
      0: return $urandom;
      1: return lo + $urandom_range(4) - 2;
      2: return hi + $urandom_range(4) - 2;
      3: return lo + ($urandom_range(20000) - 10000) * 37;
      default: return hi + ($urandom_range(20000) - 10000) * 53;
    endcase
  endfunction

  task automatic random_points(int n, logic [31:0] lx, logic [31:0] ly,
                               logic [31:0] hx, logic [31:0] hy);
    for (int i = 0; i < n; i++) send_point(near(lx, hx), near(ly, hy));
    end_burst();
  endtask

  initial begin
    logic [31:0] lx, ly, hx, hy, t;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // default unit box: every region, edges, both extremes, exact x-min
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(-32'sd3, -32'sd4);
    send_point(32'd65539, -32'sd4);
    send_point(-32'sd1, 32'd65537);
    send_point(32'd70000, 32'd70000);
    send_point(-32'sd100, 32'd30000);
    send_point(32'd70000, 32'd30000);
    send_point(32'd30000, -32'sd100);
    send_point(32'd30000, 32'd70000);
    send_point(32'd0, 32'd30000);
    send_point(32'd0, 32'd0);
    send_point(32'd65536, 32'd65536);
    send_point(32'd65536, 32'd100);
    send_point(32'd32768, 32'd32768);
    send_point(32'd30000, 32'd65535);
    send_point(-32'sd1, 32'd0);
    send_point(32'h8000_0000, 32'd100);
    end_burst();
    wait_drained();

    // full-range box, then a degenerate point box, two inverted boxes
    load_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'd5);
    send_point(32'd0, 32'd0);
    send_point(32'h8000_0001, 32'h7FFF_FFFE);
    end_burst();
    load_box(32'd1000, 32'd1000, 32'd1000, 32'd1000);
    random_points(20, 32'd1000, 32'd1000, 32'd1000, 32'd1000);
    load_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    random_points(20, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    load_box(32'd500, 32'h8000_0000, 32'd100, 32'd0);
    random_points(20, 32'd500, 32'h8000_0000, 32'd100, 32'd0);

    for (int k = 0; k < 12; k++) begin
      lx = $urandom; ly = $urandom; hx = $urandom; hy = $urandom;
      if ($signed(lx) > $signed(hx)) begin t = lx; lx = hx; hx = t; end
      if ($signed(ly) > $signed(hy)) begin t = ly; ly = hy; hy = t; end
      if (k % 3 == 0) begin
        lx = $urandom_range(200000) - 100000;
        ly = $urandom_range(200000) - 100000;
        hx = lx + $urandom_range(300000);
        hy = ly + $urandom_range(300000);
      end
      load_box(lx, ly, hx, hy);
      no_stall = (k == 5);
      random_points(50, lx, ly, hx, hy);
      no_stall = 0;
    end

    wait_drained();
    $display("%0d boxes, %0d results checked, all nine regions and range extremes",
             box_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("point_box_signed_distance_top_tb: clean");
    end else begin
      $display("point_box_signed_distance_top_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
